FILE: hdl/upd_pkg.sv
package upd_pkg;

    // Result bundle of one input transaction
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 2;
    localparam int BYTE_W  = 8;

    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               count;
        logic                           done;
    } upd_res_t;

endpackage

FILE: hdl/upd_step.sv
module upd_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         char_in,
    input  logic               end_in,
    output upd_pkg::upd_res_t  res,
    output logic               idle
);
    import upd_pkg::*;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // position of the next character inside a three-character chunk
    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_TRAIL = 2'd1;
    localparam logic [1:0] PH_SEP   = 2'd2;

    localparam logic [CNT_W-1:0] KIND_NONE   = CNT_W'(0);
    localparam logic [CNT_W-1:0] KIND_SINGLE = CNT_W'(1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PCT,
        MODE_FIRST,
        MODE_GROUP
    } mode_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_of(logic [7:0] c);
        logic [4:0] h;
        h = 5'b0;
        if (c >= "0" && c <= "9")
            h = {1'b1, c[3:0]};
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            h = {1'b1, 4'(c[3:0] + 4'd9)};
        return h;
    endfunction

    function automatic logic [7:0] lower_of(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function automatic logic can_start(logic [7:0] c);
        logic [7:0] l;
        l = lower_of(c);
        return (c >= "0" && c <= "7") || (l >= "c" && l <= "f");
    endfunction

    // byte count of the group, KIND_NONE when rejected
    function automatic logic [CNT_W-1:0] group_kind(logic [7:0] a, logic [7:0] b);
        logic [7:0]       la;
        logic [7:0]       lb;
        logic [4:0]       hb;
        logic [CNT_W-1:0] k;
        la = lower_of(a);
        lb = lower_of(b);
        hb = hex_of(b);
        k  = KIND_NONE;
        if (a >= "0" && a <= "7" && hb[4])
            k = KIND_SINGLE;
        else if (la == "c" && ((b >= "2" && b <= "9") || (lb >= "a" && lb <= "f")))
            k = CNT_W'(2);
        else if (la == "d" && hb[4])
            k = CNT_W'(2);
        else if (la == "e" && hb[4])
            k = CNT_W'(3);
        else if (la == "f" && b >= "0" && b <= "4")
            k = CNT_W'(4);
        return k;
    endfunction

    // value of the leading hex digits of a pair
    function automatic logic [7:0] pair_val(logic [4:0] ha, logic [4:0] hb);
        logic [7:0] v;
        if (!ha[4])
            v = 8'h00;
        else if (!hb[4])
            v = {4'b0, ha[3:0]};
        else
            v = {ha[3:0], hb[3:0]};
        return v;
    endfunction

    function automatic upd_res_t put_byte(upd_res_t r, logic [7:0] v);
        upd_res_t o;
        o = r;
        if (r.count < CNT_W'(MAX_RES))
        begin
            o.bytes[r.count[IDX_W-1:0]] = v;
            o.count = r.count + CNT_W'(1);
        end
        return o;
    endfunction

    mode_t                           mode_reg, mode_next;
    logic [7:0]                      first_reg, first_next;
    logic [3:0]                      nib_reg, nib_next;
    logic                            nibv_reg, nibv_next;
    logic [MAX_RES-1:0][BYTE_W-1:0]  pairs_reg, pairs_next;
    logic [1:0]                      phase_reg, phase_next;
    logic [IDX_W-1:0]                pidx_reg, pidx_next;
    logic [CNT_W-1:0]                glen_reg, glen_next;

    upd_res_t          res_c;
    logic [4:0]        hx_c;
    logic [4:0]        hx_first;
    logic [CNT_W-1:0]  kind;
    logic [7:0]        pv;
    logic [7:0]        flush_val;
    logic              do_plain;

    // one transaction: feed the character, then close out at end of text
    always_comb
    begin
        mode_next  = mode_reg;
        first_next = first_reg;
        nib_next   = nib_reg;
        nibv_next  = nibv_reg;
        pairs_next = pairs_reg;
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        glen_next  = glen_reg;
        res_c      = '0;
        do_plain   = 1'b0;
        flush_val  = 8'h00;
        hx_c       = hex_of(char_in);
        hx_first   = hex_of(first_reg);
        kind       = group_kind(first_reg, char_in);
        pv         = pair_val({nibv_reg, nib_reg}, hx_c);

        unique case (mode_reg)
            MODE_IDLE:
            begin
                do_plain = 1'b1;
            end
            MODE_PCT:
            begin
                if (!can_start(char_in))
                begin
                    res_c     = put_byte(res_c, CH_PCT);
                    mode_next = MODE_IDLE;
                    do_plain  = 1'b1;
                end
                else
                begin
                    first_next = char_in;
                    mode_next  = MODE_FIRST;
                end
            end
            MODE_FIRST:
            begin
                if (kind == KIND_NONE)
                begin
                    res_c     = put_byte(res_c, CH_PCT);
                    res_c     = put_byte(res_c, first_reg);
                    mode_next = MODE_IDLE;
                    do_plain  = 1'b1;
                end
                else if (kind == KIND_SINGLE)
                begin
                    res_c     = put_byte(res_c, pair_val(hx_first, hx_c));
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    pairs_next[0] = pair_val(hx_first, hx_c);
                    glen_next     = kind;
                    pidx_next     = '0;
                    phase_next    = PH_SEP;
                    mode_next     = MODE_GROUP;
                end
            end
            MODE_GROUP:
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        nib_next   = hx_c[3:0];
                        nibv_next  = hx_c[4];
                        phase_next = PH_TRAIL;
                    end
                    PH_TRAIL:
                    begin
                        pairs_next[pidx_reg] = pv;
                        if (CNT_W'(pidx_reg) + CNT_W'(1) == glen_reg)
                        begin
                            // last pair complete: emit the whole group
                            for (int p = 0; p < MAX_RES; p++)
                            begin
                                if (CNT_W'(p) < glen_reg)
                                    res_c = put_byte(res_c, pairs_next[p]);
                            end
                            mode_next = MODE_IDLE;
                            glen_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_SEP;
                        end
                    end
                    PH_SEP:
                    begin
                        phase_next = PH_LEAD;
                        pidx_next  = pidx_reg + IDX_W'(1);
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        glen_next = '0;
                    end
                endcase
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // plain character, also after a rejected escape
        if (do_plain)
        begin
            if (char_in == CH_PCT)
            begin
                mode_next = MODE_PCT;
                glen_next = '0;
            end
            else
            begin
                res_c = put_byte(res_c, (char_in == CH_PLUS) ? CH_SPACE : char_in);
            end
        end

        // end of text: missing characters read as NUL
        if (end_in)
        begin
            unique case (mode_next)
                MODE_IDLE:
                begin
                end
                MODE_PCT:
                begin
                    res_c = put_byte(res_c, CH_PCT);
                end
                MODE_FIRST:
                begin
                    res_c = put_byte(res_c, CH_PCT);
                    res_c = put_byte(res_c, first_next);
                end
                MODE_GROUP:
                begin
                    for (int p = 0; p < MAX_RES; p++)
                    begin
                        if (CNT_W'(p) < glen_next)
                        begin
                            if (IDX_W'(p) < pidx_next ||
                                (IDX_W'(p) == pidx_next && phase_next == PH_SEP))
                                flush_val = pairs_next[p];
                            else if (IDX_W'(p) == pidx_next && phase_next == PH_TRAIL)
                                flush_val = nibv_next ? {4'b0, nib_next} : 8'h00;
                            else
                                flush_val = 8'h00;
                            res_c = put_byte(res_c, flush_val);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_IDLE;
            glen_next = '0;
        end

        res_c.done = end_in;
    end

    // decoder state, advanced once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= PH_LEAD;
            pidx_reg  <= '0;
            glen_reg  <= '0;
            first_reg <= '0;
            nib_reg   <= '0;
            nibv_reg  <= 1'b0;
            pairs_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            pidx_reg  <= pidx_next;
            glen_reg  <= glen_next;
            first_reg <= first_next;
            nib_reg   <= nib_next;
            nibv_reg  <= nibv_next;
            pairs_reg <= pairs_next;
        end
    end

    assign res  = res_c;
    assign idle = (mode_reg == MODE_IDLE);

endmodule

FILE: hdl/upd_out.sv
module upd_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  upd_pkg::upd_res_t  res,
    output logic               free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // decoded_byte
    output logic               m_axis_tuser,   // run_last
    output logic               m_axis_tlast    // text_done
);
    import upd_pkg::*;

    logic [MAX_RES-1:0][BYTE_W-1:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0]               rem_reg, rem_next;
    logic                           done_reg, done_next;
    logic                           take;

    assign take = m_axis_tvalid && m_axis_tready;
    // bundle can be replaced when empty or its final byte leaves now
    assign free = (rem_reg == '0) || (rem_reg == CNT_W'(1) && m_axis_tready);

    // load a new bundle or shift out the head byte
    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;
        if (load)
        begin
            bytes_next = res.bytes;
            rem_next   = res.count;
            done_next  = res.done;
        end
        else if (take)
        begin
            bytes_next = bytes_reg >> BYTE_W;
            rem_next   = rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
        end
    end

    assign m_axis_tvalid = (rem_reg != '0);
    assign m_axis_tdata  = bytes_reg[0];
    assign m_axis_tuser  = (rem_reg == CNT_W'(1));
    assign m_axis_tlast  = (rem_reg == CNT_W'(1)) && done_reg;

endmodule

FILE: hdl/uri_percent_decoder.sv
// An input transaction's first decoded byte passes the input register, then the
// output bundle register, before it leaves as an output transaction.
// Throughput: one input byte per cycle; an input producing more than one byte holds
// the output bundle register until its last byte leaves, so inputs stall behind
// multi-byte runs and while the receiver holds m_axis_tready low.
// Reset (rst_n low, asynchronous): decoder idle, input and output registers empty.
module uri_percent_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // text_char
    input  logic       s_axis_tlast,   // text_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // decoded_byte
    output logic       m_axis_tuser,   // run_last
    output logic       m_axis_tlast    // text_done
);
    import upd_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       fire;
    logic       out_load;
    logic       out_free;
    logic       step_idle;
    upd_res_t   step_res;

    // held item advances when its results fit into the output stage
    assign fire          = in_vld_reg && ((step_res.count == '0) || out_free);
    assign out_load      = fire && (step_res.count != '0);
    assign s_axis_tready = !in_vld_reg || fire;

    // input register
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            in_char_reg <= '0;
            in_end_reg  <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_char_reg <= s_axis_tdata;
                in_end_reg  <= s_axis_tlast;
            end
        end
    end

    upd_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .char_in (in_char_reg),
        .end_in  (in_end_reg),
        .res     (step_res),
        .idle    (step_idle)
    );

    upd_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (step_res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // output bundle is never overwritten while bytes remain
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output bundle overwritten");

    // end of text always yields a result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_end_reg) |-> (step_res.count != '0))
        else $error("end of text without result");

    // decoder returns to idle after end of text
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_end_reg) |=> step_idle)
        else $error("decoder not idle after end of text");

    // bundle count stays within its capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (step_res.count <= CNT_W'(MAX_RES)))
        else $error("result count out of range");

endmodule

FILE: tb/uri_percent_decoder_tb.sv
module uri_percent_decoder_tb;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int         MAX_OUT  = 4;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         TAIL_CYCLES = 10;
    localparam int         TEXT_TARGET = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       done;
    } dec_byte_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY_4TH, RX_MOSTLY} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // text_char
    logic       s_axis_tlast = 1'b0;    // text_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // decoded_byte
    logic       m_axis_tuser;           // run_last
    logic       m_axis_tlast;           // text_done

    uri_percent_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Stimulus and expectation stores
    text_item_t text_q[$];
    dec_byte_t  decoded_q[$];
    logic [7:0] step_bytes[$];

    // Decoder shadow state
    logic [7:0]  held_chars [0:10];
    int unsigned held_cnt  = 0;
    int unsigned grp_bytes = 0;

    int errors       = 0;
    int texts_built  = 0;
    int chars_sent   = 0;
    int bytes_seen   = 0;
    int groups_done  = 0;
    int full_steps   = 0;
    int quiet_cycles = 0;

    int          burst_left = 0;
    int          gap_left   = 0;
    rx_mode_t    rx_mode    = RX_OPEN;
    int          rx_span    = 0;
    logic [31:0] cycle_ctr  = 0;

    string HEX_SET = "0123456789abcdefABCDEF";
    string C2_SET  = "23456789abcdefABCDEF";

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Decoder predictor
    // ---------------------------------------------------------------
    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit may_open(input logic [7:0] c);
        logic [7:0] l;
        l = fold_case(c);
        return (c >= "0" && c <= "7") || (l >= "c" && l <= "f");
    endfunction

    // 0: not an escape, 1: single byte, 2..4: byte count of a group
    function automatic int escape_kind(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] la;
        logic [7:0] lb;
        bit         bhex;
        la   = fold_case(a);
        lb   = fold_case(b);
        bhex = hex_val(b) >= 0;
        if (a >= "0" && a <= "7" && bhex) return 1;
        if (la == "c" && ((b >= "2" && b <= "9") || (lb >= "a" && lb <= "f"))) return 2;
        if (la == "d" && bhex) return 2;
        if (la == "e" && bhex) return 3;
        if (la == "f" && b >= "0" && b <= "4") return 4;
        return 0;
    endfunction

    // Leading hex digits only: one digit alone, none gives zero
    function automatic logic [7:0] chunk_value(input logic [7:0] a, input logic [7:0] b);
        int ha;
        int hb;
        ha = hex_val(a);
        hb = hex_val(b);
        if (ha < 0) return 8'h00;
        if (hb < 0) return 8'(ha);
        return 8'((ha << 4) | hb);
    endfunction

    // Chars past the end of the text read as NUL
    function automatic logic [7:0] held_at(input int unsigned i);
        int unsigned avail;
        avail = (held_cnt > 0) ? held_cnt - 1 : 0;
        if (i < avail && i < 11) return held_chars[i];
        return 8'h00;
    endfunction

    task automatic emit(input logic [7:0] b);
        if (step_bytes.size() < MAX_OUT) step_bytes.push_back(b);
    endtask

    task automatic flush_group();
        for (int unsigned p = 0; p < grp_bytes && p < 4; p++)
            emit(chunk_value(held_at(3 * p), held_at(3 * p + 1)));
        groups_done++;
        held_cnt  = 0;
        grp_bytes = 0;
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == CH_PCT) begin
            held_cnt  = 1;
            grp_bytes = 0;
        end else begin
            emit(c == CH_PLUS ? CH_SPACE : c);
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        int          k;
        logic [7:0]  first;
        int unsigned idx;
        if (held_cnt == 0) begin
            take_plain(c);
        end else if (held_cnt == 1) begin
            // early rejection: '%' goes out literally, char is rescanned
            if (!may_open(c)) begin
                emit(CH_PCT);
                held_cnt  = 0;
                grp_bytes = 0;
                take_plain(c);
            end else begin
                held_chars[0] = c;
                held_cnt = 2;
            end
        end else if (held_cnt == 2) begin
            first = held_chars[0];
            k = escape_kind(first, c);
            if (k == 0) begin
                emit(CH_PCT);
                emit(first);
                held_cnt  = 0;
                grp_bytes = 0;
                take_plain(c);
            end else if (k == 1) begin
                emit(chunk_value(first, c));
                held_cnt  = 0;
                grp_bytes = 0;
            end else begin
                held_chars[1] = c;
                grp_bytes = k;
                held_cnt  = 3;
            end
        end else begin
            idx = held_cnt - 1;
            if (idx < 11) held_chars[idx] = c;
            held_cnt++;
            if (grp_bytes < 2 || grp_bytes > 4 || idx >= 3 * grp_bytes - 2)
                flush_group();
        end
    endtask

    task automatic close_text();
        if (held_cnt == 1) begin
            emit(CH_PCT);
            held_cnt  = 0;
            grp_bytes = 0;
        end else if (held_cnt == 2) begin
            emit(CH_PCT);
            emit(held_chars[0]);
            held_cnt  = 0;
            grp_bytes = 0;
        end else if (held_cnt >= 3) begin
            flush_group();
        end
    endtask

    task automatic predict_step(input logic [7:0] c, input logic last);
        dec_byte_t d;
        step_bytes.delete();
        scan_char(c);
        if (last) close_text();
        if (step_bytes.size() == MAX_OUT) full_steps++;
        foreach (step_bytes[i]) begin
            d.data     = step_bytes[i];
            d.run_last = (i == step_bytes.size() - 1);
            d.done     = last && (i == step_bytes.size() - 1);
            decoded_q.push_back(d);
        end
    endtask

    // ---------------------------------------------------------------
    // Text generation
    // ---------------------------------------------------------------
    task automatic push_char(input logic [7:0] c, input logic last);
        text_item_t t;
        t.ch   = c;
        t.last = last;
        text_q.push_back(t);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
        texts_built++;
    endtask

    function automatic logic [7:0] rand_hex();
        return HEX_SET[$urandom_range(0, HEX_SET.len() - 1)];
    endfunction

    // Mostly a hex digit, sometimes any byte
    function automatic logic [7:0] chunk_char();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return rand_hex();
    endfunction

    function automatic logic [7:0] rand_case(input logic [7:0] c);
        return $urandom_range(0, 1) ? c - 8'd32 : c;
    endfunction

    task automatic make_text();
        logic [7:0] seg[$];
        logic [7:0] txt[$];
        int         nseg;
        int         kind;
        int         glen;
        int         keep;
        nseg = $urandom_range(1, 8);
        for (int s = 0; s < nseg; s++) begin
            seg.delete();
            kind = $urandom_range(0, 99);
            if (kind < 18) begin
                seg.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 33) begin
                seg.push_back(8'($urandom_range(97, 122)));
            end else if (kind < 40) begin
                seg.push_back(CH_PLUS);
            end else if (kind < 55) begin
                // single-byte escape
                seg.push_back(CH_PCT);
                seg.push_back(8'($urandom_range(48, 55)));
                seg.push_back(rand_hex());
            end else if (kind < 85) begin
                // multi-byte group
                glen = $urandom_range(2, 4);
                seg.push_back(CH_PCT);
                case (glen)
                    2: begin
                        if ($urandom_range(0, 1)) begin
                            seg.push_back(rand_case("c"));
                            seg.push_back(C2_SET[$urandom_range(0, C2_SET.len() - 1)]);
                        end else begin
                            seg.push_back(rand_case("d"));
                            seg.push_back(rand_hex());
                        end
                    end
                    3: begin
                        seg.push_back(rand_case("e"));
                        seg.push_back(rand_hex());
                    end
                    default: begin
                        seg.push_back(rand_case("f"));
                        seg.push_back(8'($urandom_range(48, 52)));
                    end
                endcase
                for (int p = 1; p < glen; p++) begin
                    seg.push_back($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
                                                            : CH_PCT);
                    seg.push_back(chunk_char());
                    seg.push_back(chunk_char());
                end
            end else if (kind < 93) begin
                seg.push_back(CH_PCT);
                seg.push_back(8'($urandom_range(0, 255)));
            end else begin
                // likely a rejected pair
                seg.push_back(CH_PCT);
                seg.push_back(rand_case(8'($urandom_range(99, 102))));
                seg.push_back(8'($urandom_range(0, 255)));
            end
            // text may end in the middle of an escape
            if (s == nseg - 1 && seg.size() > 1 && $urandom_range(0, 3) == 0) begin
                keep = $urandom_range(1, seg.size() - 1);
                while (seg.size() > keep) void'(seg.pop_back());
            end
            txt = {txt, seg};
        end
        foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
        texts_built++;
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of transactions separated by random gaps
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        text_item_t nxt;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_step(s_axis_tdata, s_axis_tlast);
                chars_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (text_q.size() > 0) begin
                nxt = text_q.pop_front();
                s_axis_tdata  <= nxt.ch;
                s_axis_tlast  <= nxt.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall pattern: random modes, each held for a random number of cycles
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_span = $urandom_range(20, 80);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                RX_OPEN:      m_axis_tready <= 1'b1;
                RX_COIN:      m_axis_tready <= 1'($urandom_range(0, 1));
                RX_EVERY_4TH: m_axis_tready <= (cycle_ctr[1:0] == 2'b11);
                default:      m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each output transaction with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        dec_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            bytes_seen++;
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h user=%0b last=%0b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch($sformatf("byte %0d: data %02h, expected %02h",
                                              bytes_seen, m_axis_tdata, want.data));
                if (m_axis_tuser !== want.run_last)
                    report_mismatch($sformatf("byte %0d: run_last %0b, expected %0b",
                                              bytes_seen, m_axis_tuser, want.run_last));
                if (m_axis_tlast !== want.done)
                    report_mismatch($sformatf("byte %0d: text_done %0b, expected %0b",
                                              bytes_seen, m_axis_tlast, want.done));
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed texts, random texts, reset, drain, verdict
    // ---------------------------------------------------------------
    initial begin
        // two-byte group, unfinished group, '%' rescanned then rejected pair
        add_text("%c3%a9");
        add_text("%E2%8");
        add_text("%%c1");
        // undecided pair and lone '%' at end of text
        add_text("%7");
        add_text("%");
        // extreme bytes, single-byte escape, plus sign
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_PCT, 1'b0);
        push_char("4", 1'b0);
        push_char("1", 1'b0);
        push_char(CH_PLUS, 1'b1);
        texts_built++;
        // four-byte group cut short, upper-case lead
        add_text("%F0x");

        while (text_q.size() < TEXT_TARGET + 28)
            make_text();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (text_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d texts, %0d input bytes, %0d decoded bytes checked",
                 texts_built, chars_sent, bytes_seen);
        $display("Groups closed: %0d, bytes giving four outputs: %0d, mismatches: %0d",
                 groups_done, full_steps, errors);
        if (errors == 0 && decoded_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/upd_pkg.sv
hdl/upd_step.sv
hdl/upd_out.sv
hdl/uri_percent_decoder.sv
tb/uri_percent_decoder_tb.sv
